/* sv/pu_pkg.sv */
// Shared package for the phase unwrapper.
// Holds the default sample format, the fixed-point pi source constant and
// the queue item type. It depends on nothing else.
package pu_pkg;

  // Default number of fraction bits in the phase samples.
  localparam int PHASE_FRAC_BITS_DEF = 24;

  // Pi with 60 fraction bits; the working value is rounded from this.
  localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;

  // Reset value of the cutoff register (pi in unsigned Q7.24).
  localparam logic [30:0] CUTOFF_RST = 31'd52707179;

  // Depth of the queue between the front and back parts.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // One classified sample as it travels from the front to the back part.
  typedef struct packed {
    logic signed [31:0] phase;
    logic               last;
    logic               first;
    logic signed [32:0] dp;
  } pu_item_t;

endpackage

/* sv/pu_front.sv */
// Front part of the phase unwrapper: accepts samples and classifies them.
// Keeps the previous raw sample and the sequence flag and forms the raw
// difference. Depends on pu_pkg.
module pu_front
  import pu_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic signed [31:0] in_phase_in,
  input  logic               in_last_in,
  input  logic               q_full,
  output logic               push,
  output pu_item_t           push_item
);

  logic signed [31:0] prev_r;
  logic               have_prev_r;

  // A transfer happens whenever a sample is valid and the queue has room.
  assign push = in_valid && !q_full;

  // Classify the sample and form its difference from the previous one.
  always_comb begin
    push_item.phase = in_phase_in;
    push_item.last  = in_last_in;
    push_item.first = !have_prev_r;
    push_item.dp    = {in_phase_in[31], in_phase_in} - {prev_r[31], prev_r};
  end

  // Sequence state; a sample flagged last makes the next one start fresh.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r      <= '0;
      have_prev_r <= 1'b0;
    end else if (push) begin
      prev_r      <= in_phase_in;
      have_prev_r <= !in_last_in;
    end
  end

endmodule

/* sv/pu_queue.sv */
// Short queue between the front and back parts of the phase unwrapper.
// Lets the front keep accepting while the back part is held by its output.
// Depends on pu_pkg.
module pu_queue
  import pu_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  pu_item_t push_item,
  input  logic     pop,
  output pu_item_t pop_item,
  output logic     empty,
  output logic     full
);

  pu_item_t            entries_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r;
  logic [QPTR_W-1:0]   rd_ptr_r;
  logic [QCNT_W-1:0]   cnt_r;
  logic [QCNT_W-1:0]   cnt_nxt;

  assign empty    = (cnt_r == '0);
  assign full     = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign pop_item = entries_r[rd_ptr_r];

  // Occupancy follows the two transfers.
  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  // Pointers wrap at the queue depth.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

/* sv/pu_back.sv */
// Back part of the phase unwrapper: wraps the difference, builds the
// correction, keeps the running sum and drives the result register.
// Depends on pu_pkg.
module pu_back
  import pu_pkg::*;
#(
  parameter int PHASE_FRAC_BITS = PHASE_FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [30:0]        cfg_wdata,
  input  pu_item_t           q_item,
  input  logic               q_empty,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [39:0] out_phase_out,
  output logic               out_last_out
);

  // Fixed-point pi, 2*pi, an offset that makes the wrap operand
  // non-negative, and the reciprocal of 2*pi scaled by 2^UW.
  localparam int          F      = PHASE_FRAC_BITS;
  localparam logic [63:0] PI_FIX = (PI_Q60 + (64'd1 << (59 - F))) >> (60 - F);
  localparam logic [63:0] TWO_PI = PI_FIX << 1;
  localparam int          TW     = F + 3;
  localparam int          UW     = 34;
  localparam int          QW     = 32 - F;
  localparam int          PW     = QW + TW;
  localparam logic [63:0] KWRAP  = ((64'd1 << 32) + TWO_PI - 64'd1) / TWO_PI;
  localparam logic [63:0] OFF    = KWRAP * TWO_PI;
  localparam logic [63:0] RECIP  = (64'd1 << UW) / TWO_PI;

  localparam logic [PW-1:0] T_P = TWO_PI[PW-1:0];

  function automatic logic signed [39:0] sat40(input logic signed [40:0] v);
    logic signed [39:0] r;
    if (v[40] != v[39]) begin
      r = v[40] ? {1'b1, {39{1'b0}}} : {1'b0, {39{1'b1}}};
    end else begin
      r = v[39:0];
    end
    return r;
  endfunction

  logic [30:0] cutoff_r;
  logic        en;

  // Stage valids.
  logic a_vld_r, b_vld_r, c_vld_r, d_vld_r, e_vld_r, f_vld_r, out_vld_r;

  // Stage payloads.
  logic signed [31:0] a_phase_r, b_phase_r, c_phase_r, d_phase_r, e_phase_r, f_phase_r;
  logic               a_last_r, b_last_r, c_last_r, d_last_r, e_last_r, f_last_r;
  logic               a_first_r, b_first_r, c_first_r, d_first_r, e_first_r;
  logic               a_big_r, b_big_r, c_big_r, d_big_r;
  logic               a_pos_r, b_pos_r, c_pos_r;
  logic [UW-1:0]      a_u_r, b_u_r, c_u_r;
  logic [QW-1:0]      b_q_r;
  logic [PW-1:0]      c_qt_r, d_qt_r;
  logic               d_fix_r, d_spec_r;
  logic signed [33:0] e_corr_r;
  logic signed [39:0] sum_r;
  logic signed [39:0] out_phase_r;
  logic               out_last_r;

  // Combinational helpers.
  logic [34:0]        a_usum;
  logic [32:0]        a_mag;
  logic [UW+QW-1:0]   b_prod;
  logic [PW-1:0]      d_r0;
  logic [PW-1:0]      d_r;
  logic               d_fix;
  logic [35:0]        e_corr;
  logic signed [39:0] f_sum_nxt;
  logic signed [39:0] out_phase_nxt;

  // The whole back pipeline moves unless a result waits on a stall.
  assign en            = !(out_vld_r && out_stall);
  assign q_pop         = en && !q_empty;
  assign out_valid     = out_vld_r;
  assign out_phase_out = out_phase_r;
  assign out_last_out  = out_last_r;

  // Cutoff register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cutoff_r <= CUTOFF_RST;
    end else if (cfg_we) begin
      cutoff_r <= cfg_wdata;
    end
  end

  // Stage valids.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r   <= 1'b0;
      b_vld_r   <= 1'b0;
      c_vld_r   <= 1'b0;
      d_vld_r   <= 1'b0;
      e_vld_r   <= 1'b0;
      f_vld_r   <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (en) begin
      a_vld_r   <= !q_empty;
      b_vld_r   <= a_vld_r;
      c_vld_r   <= b_vld_r;
      d_vld_r   <= c_vld_r;
      e_vld_r   <= d_vld_r;
      f_vld_r   <= e_vld_r;
      out_vld_r <= f_vld_r;
    end
  end

  // Stage A: offset the difference by pi plus a multiple of 2*pi, and
  // compare its magnitude with the cutoff.
  always_comb begin
    a_usum = {{2{q_item.dp[32]}}, q_item.dp} + PI_FIX[34:0] + OFF[34:0];
    a_mag  = q_item.dp[32] ? (33'd0 - q_item.dp) : q_item.dp;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_phase_r <= q_item.phase;
      a_last_r  <= q_item.last;
      a_first_r <= q_item.first;
      a_u_r     <= a_usum[UW-1:0];
      a_big_r   <= (a_mag >= {2'b00, cutoff_r});
      a_pos_r   <= !q_item.dp[32] && (q_item.dp != '0);
    end
  end

  // Stage B: quotient estimate by the reciprocal; it is low by at most one.
  assign b_prod = {{QW{1'b0}}, a_u_r} * {{UW{1'b0}}, RECIP[QW-1:0]};

  always_ff @(posedge clk) begin
    if (en) begin
      b_phase_r <= a_phase_r;
      b_last_r  <= a_last_r;
      b_first_r <= a_first_r;
      b_big_r   <= a_big_r;
      b_pos_r   <= a_pos_r;
      b_u_r     <= a_u_r;
      b_q_r     <= b_prod[UW+QW-1:UW];
    end
  end

  // Stage C: multiple of 2*pi for the estimated quotient.
  always_ff @(posedge clk) begin
    if (en) begin
      c_phase_r <= b_phase_r;
      c_last_r  <= b_last_r;
      c_first_r <= b_first_r;
      c_big_r   <= b_big_r;
      c_pos_r   <= b_pos_r;
      c_u_r     <= b_u_r;
      c_qt_r    <= {{TW{1'b0}}, b_q_r} * {{QW{1'b0}}, TWO_PI[TW-1:0]};
    end
  end

  // Stage D: remainder, one-step quotient fix, and the case where the
  // wrapped value lands on -pi for a rising jump and becomes +pi.
  always_comb begin
    d_r0  = {1'b0, c_u_r} - c_qt_r;
    d_fix = (d_r0 >= T_P);
    d_r   = d_fix ? (d_r0 - T_P) : d_r0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_phase_r <= c_phase_r;
      d_last_r  <= c_last_r;
      d_first_r <= c_first_r;
      d_big_r   <= c_big_r;
      d_qt_r    <= c_qt_r;
      d_fix_r   <= d_fix;
      d_spec_r  <= (d_r == '0) && c_pos_r;
    end
  end

  // Stage E: the correction equals the offset minus the true multiple of
  // 2*pi, plus 2*pi when -pi was turned into +pi.
  always_comb begin
    e_corr = OFF[35:0] - {{(36 - PW){1'b0}}, d_qt_r};
    if (d_fix_r && !d_spec_r) begin
      e_corr = e_corr - {{(36 - PW){1'b0}}, T_P};
    end else if (d_spec_r && !d_fix_r) begin
      e_corr = e_corr + {{(36 - PW){1'b0}}, T_P};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_phase_r <= d_phase_r;
      e_last_r  <= d_last_r;
      e_first_r <= d_first_r;
      e_corr_r  <= d_big_r ? e_corr[33:0] : '0;
    end
  end

  // Stage F: running correction sum, cleared at the start of a sequence.
  assign f_sum_nxt = e_first_r ? '0
                   : sat40({sum_r[39], sum_r} + {{7{e_corr_r[33]}}, e_corr_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
    end else if (en && e_vld_r) begin
      sum_r <= f_sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_phase_r <= e_phase_r;
      f_last_r  <= e_last_r;
    end
  end

  // Output register: raw sample plus the sum, saturated.
  assign out_phase_nxt = sat40({{9{f_phase_r[31]}}, f_phase_r} + {sum_r[39], sum_r});

  always_ff @(posedge clk) begin
    if (en) begin
      out_phase_r <= out_phase_nxt;
      out_last_r  <= f_last_r;
    end
  end

endmodule

/* sv/phase_unwrap.sv */
// Top level of the streaming phase unwrapper.
// Connects the front part, the queue and the back part. Depends on pu_pkg,
// pu_front, pu_queue and pu_back.
//
//   Channel   Direction  Handshake             Payload
//   in_       input      in_valid / in_stall   in_phase_in, in_last_in
//   out_      output     out_valid / out_stall out_phase_out, out_last_out
//   cfg_      input      cfg_we                cfg_wdata (cutoff)
//
// One sample is taken and one result given per cycle, sustained while
// out_stall is low. A result passes from its input transfer through the
// queue, then through the back pipeline registers A to F and the output
// register; the two registered multiplies in B and C form the modulo by
// 2*pi. Reset is synchronous and active low; it clears the sequence state,
// the running sum and the cutoff to pi. A stall on the output freezes the
// back pipeline; the queue of four then fills before in_stall rises.
module phase_unwrap
  import pu_pkg::*;
#(
  parameter int PHASE_FRAC_BITS = PHASE_FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [30:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_phase_in,
  input  logic               in_last_in,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [39:0] out_phase_out,
  output logic               out_last_out
);

  logic     push;
  logic     pop;
  logic     q_full;
  logic     q_empty;
  pu_item_t push_item;
  pu_item_t pop_item;

  assign in_stall = q_full;

  // Front part: transfer and classification of samples.
  pu_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_phase_in (in_phase_in),
    .in_last_in  (in_last_in),
    .q_full      (q_full),
    .push        (push),
    .push_item   (push_item)
  );

  // Queue between the two parts.
  pu_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .empty     (q_empty),
    .full      (q_full)
  );

  // Back part: wrap, correction, sum and result register.
  pu_back #(
    .PHASE_FRAC_BITS (PHASE_FRAC_BITS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .q_item        (pop_item),
    .q_empty       (q_empty),
    .q_pop         (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_phase_out (out_phase_out),
    .out_last_out  (out_last_out)
  );

endmodule

/* bench/testbench.sv */
// Self-checking bench for phase_unwrap: directed rows, random sequences and
// sawtooth runs that saturate the running sum, checked against a predictor.
// Depends on pu_pkg and the phase_unwrap RTL.
module testbench;
  import pu_pkg::*;

  // Fixed-point pi, rounded half up from the 60-fraction-bit constant.
  localparam longint PI_FIX = longint'((PI_Q60 + (64'd1 << (59 - PHASE_FRAC_BITS_DEF)))
                                        >> (60 - PHASE_FRAC_BITS_DEF));
  localparam longint TWO_PI = 2 * PI_FIX;
  localparam longint SUM_MAX = (longint'(1) <<< 39) - 1;
  localparam longint SUM_MIN = -(longint'(1) <<< 39);
  localparam logic signed [31:0] PI32 = 32'(PI_FIX);
  localparam logic signed [39:0] PI40 = 40'(PI_FIX);
  localparam logic [30:0] CUTOFF_MAX = 31'h7FFFFFFF;
  localparam int WAIT_MAX = 8;
  localparam int SAW_JUMPS = 129;

  typedef struct {
    logic signed [31:0] phase;
    logic               last;
    logic               typed;
    logic signed [39:0] want;
  } stim_row_t;

  typedef struct {
    logic signed [39:0] phase;
    logic               last;
  } unwrap_result_t;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [30:0]        cfg_wdata;
  logic               in_valid;
  logic               in_stall;
  logic signed [31:0] in_phase_in;
  logic               in_last_in;
  logic               out_valid;
  logic               out_stall;
  logic signed [39:0] out_phase_out;
  logic               out_last_out;

  // Predictor state, mirroring the block's sequence state and register.
  logic [30:0]        cutoff_now;
  logic signed [31:0] prev_sample;
  longint             run_sum;
  bit                 seq_open;

  unwrap_result_t pending_phase_out[$];
  unwrap_result_t head_result;
  int             mismatch_count;
  bit             calm;

  // Directed rows; typed expectations hold for sequence starts, pi and 3*pi jumps.
  stim_row_t directed_rows [17] = '{
    '{32'sh7FFFFFFF, 1'b1, 1'b1, 40'sd2147483647},
    '{32'sh80000000, 1'b1, 1'b1, -40'sd2147483648},
    '{32'sd0,        1'b0, 1'b1, 40'sd0},
    '{PI32,          1'b0, 1'b1, PI40},
    '{32'sd0,        1'b0, 1'b1, 40'sd0},
    '{3 * PI32,      1'b0, 1'b1, PI40},
    '{32'sd0,        1'b0, 1'b1, 40'sd0},
    '{PI32 - 1,      1'b0, 1'b0, 40'sd0},
    '{32'sh7FFFFFFF, 1'b0, 1'b0, 40'sd0},
    '{32'sh80000000, 1'b0, 1'b0, 40'sd0},
    '{32'sh80000000, 1'b1, 1'b0, 40'sd0},
    '{32'sd12345,    1'b0, 1'b1, 40'sd12345},
    '{32'sd12345 + PI32 + 1, 1'b0, 1'b0, 40'sd0},
    '{32'sd5,        1'b1, 1'b0, 40'sd0},
    '{-32'sd1,       1'b1, 1'b1, -40'sd1},
    '{32'shAAAAAAAA, 1'b0, 1'b1, -40'sd1431655766},
    '{32'sh55555555, 1'b1, 1'b0, 40'sd0}
  };

  phase_unwrap u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_phase_in   (in_phase_in),
    .in_last_in    (in_last_in),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_phase_out (out_phase_out),
    .out_last_out  (out_last_out)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic longint clamp40(longint v);
    if (v > SUM_MAX) return SUM_MAX;
    if (v < SUM_MIN) return SUM_MIN;
    return v;
  endfunction

  // Unwrapped output for one sample; advances the predictor state.
  function automatic logic signed [39:0] unwrapped_phase(logic signed [31:0] sample,
                                                         logic last);
    longint jump;
    longint folded;
    longint fix;
    if (!seq_open) begin
      run_sum = 0;
    end else begin
      jump = longint'(sample) - longint'(prev_sample);
      folded = (jump + PI_FIX) % TWO_PI;
      if (folded < 0) folded += TWO_PI;
      folded -= PI_FIX;
      // A jump of an odd multiple of pi folds to -pi; upward jumps keep +pi.
      if (folded == -PI_FIX && jump > 0) folded = PI_FIX;
      fix = folded - jump;
      if ((jump < 0 ? -jump : jump) < longint'(cutoff_now)) fix = 0;
      run_sum = clamp40(run_sum + fix);
    end
    prev_sample = sample;
    seq_open = !last;
    return 40'(clamp40(longint'(sample) + run_sum));
  endfunction

  // Offer one sample after a random gap and record its expectation on transfer.
  task automatic send_sample(logic signed [31:0] sample, logic last, logic typed,
                             logic signed [39:0] want);
    int gap;
    unwrap_result_t res;
    gap = calm ? 0 : $urandom_range(0, WAIT_MAX);
    if (gap > 0) begin
      @(negedge clk) in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid    <= 1'b1;
    in_phase_in <= sample;
    in_last_in  <= last;
    do @(posedge clk); while (in_stall);
    res.phase = unwrapped_phase(sample, last);
    if (typed) res.phase = want;
    res.last = last;
    pending_phase_out.insert(pending_phase_out.size(), res);
  endtask

  // Drain all results, let the pipeline empty, then write the cutoff.
  task automatic write_cutoff(logic [30:0] value);
    @(negedge clk) in_valid <= 1'b0;
    while (pending_phase_out.size() != 0) @(posedge clk);
    repeat (12) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk) cfg_we <= 1'b0;
    cutoff_now = value;
  endtask

  // Random sequences mixing small steps, steps of up to 4*pi, odd multiples of
  // pi, jumps at the cutoff, repeated samples and arbitrary samples.
  task automatic random_phase(int items);
    int left;
    int len;
    int kind;
    longint step;
    logic signed [31:0] cur;
    left = items;
    while (left > 0) begin
      len = $urandom_range(1, 20);
      if (len > left) len = left;
      calm = ($urandom_range(0, 3) == 0);
      cur = $urandom;
      for (int i = 0; i < len; i++) begin
        if (i > 0) begin
          kind = $urandom_range(0, 5);
          case (kind)
            0: step = longint'($urandom_range(0, 32'(TWO_PI))) - PI_FIX;
            1: step = longint'(2 * $urandom_range(0, 2) + 1) * PI_FIX
                      + longint'($urandom_range(0, 2)) - 1;
            2: step = longint'($signed($urandom)) - longint'(cur);
            3: step = longint'(cutoff_now) + longint'($urandom_range(0, 2)) - 1;
            4: step = longint'($urandom_range(0, 32'(8 * PI_FIX))) - 4 * PI_FIX;
            default: step = 0;
          endcase
          if ($urandom_range(0, 1) == 1) step = -step;
          cur = 32'(longint'(cur) + step);
        end
        send_sample(cur, i == len - 1, 1'b0, 40'sd0);
      end
      left -= len;
    end
  endtask

  // Sawtooth over the full range: one corrected jump per three samples, all
  // in one direction, until the sum and the output saturate.
  task automatic saw_run(bit climb, int jumps);
    logic signed [31:0] low;
    logic signed [31:0] high;
    logic signed [31:0] mid;
    for (int j = 0; j < jumps; j++) begin
      calm = ($urandom_range(0, 3) == 0);
      low  = 32'sh80000000 + 32'($urandom_range(17, 32));
      high = 32'sh7FFFFFFF - 32'($urandom_range(17, 32));
      mid  = 32'($urandom_range(1, 15));
      if (climb) mid = -mid;
      if (climb) begin
        send_sample(high, 1'b0, 1'b0, 40'sd0);
        send_sample(low, 1'b0, 1'b0, 40'sd0);
      end else begin
        send_sample(low, 1'b0, 1'b0, 40'sd0);
        send_sample(high, 1'b0, 1'b0, 40'sd0);
      end
      send_sample(mid, j == jumps - 1, 1'b0, 40'sd0);
    end
  endtask

  // Output side: random stall before each transfer, none in calm stretches.
  initial begin
    int hold;
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      hold = calm ? 0 : $urandom_range(0, WAIT_MAX);
      repeat (hold) @(negedge clk) out_stall <= 1'b1;
      @(negedge clk) out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  // Compare each result transfer with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_phase_out.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result transfer: phase_out %0d last_out %0b",
                   out_phase_out, out_last_out);
      end else begin
        head_result = pending_phase_out.pop_front();
        if (out_phase_out !== head_result.phase || out_last_out !== head_result.last) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: phase_out exp %0d got %0d, last_out exp %0b got %0b",
                     head_result.phase, out_phase_out, head_result.last, out_last_out);
        end
      end
    end
  end

  // Main sequence: reset, directed rows, a random phase per cutoff, sawtooth runs.
  initial begin
    logic [30:0] cut_plan [6];
    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_wdata   = '0;
    in_valid    = 1'b0;
    in_phase_in = '0;
    in_last_in  = 1'b0;
    calm        = 1'b0;
    mismatch_count = 0;
    cutoff_now  = CUTOFF_RST;
    prev_sample = '0;
    run_sum     = 0;
    seq_open    = 1'b0;
    cut_plan = '{31'd0, CUTOFF_MAX, 31'(PI_FIX), 31'd1,
                 31'($urandom_range(0, 32'(8 * PI_FIX))), 31'($urandom)};
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      send_sample(directed_rows[i].phase, directed_rows[i].last,
                  directed_rows[i].typed, directed_rows[i].want);

    foreach (cut_plan[i]) begin
      write_cutoff(cut_plan[i]);
      random_phase(15);
    end

    write_cutoff(CUTOFF_MAX);
    saw_run(1'b0, SAW_JUMPS);
    saw_run(1'b1, SAW_JUMPS);

    write_cutoff(CUTOFF_RST);
    random_phase(15);

    @(negedge clk) in_valid <= 1'b0;
    while (pending_phase_out.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

  // Hard stop well beyond the slowest correct run.
  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

endmodule
